// ===== hw/rtl/qte_pkg.sv =====
// Shared types and constants of the quoted token extractor.
// Used by qte_ctrl, qte_datapath and quoted_token_extractor_unit.
`timescale 1ns / 1ps

package qte_pkg;

  // Default parameter values
  localparam int WS_MAX_DEF      = 32;
  localparam int COUNT_WIDTH_DEF = 16;

  // Port widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELIM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DELIM = 2'd1;

  // Delimiter reset values
  localparam logic [7:0] FIRST_DELIM_RST  = 8'd35;
  localparam logic [7:0] SECOND_DELIM_RST = 8'd10;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;

  // Open quote kind
  localparam logic [1:0] Q_NONE   = 2'd0;
  localparam logic [1:0] Q_DOUBLE = 2'd1;
  localparam logic [1:0] Q_SINGLE = 2'd2;

  // Stop cause codes
  localparam logic [1:0] CAUSE_FIRST  = 2'd0;
  localparam logic [1:0] CAUSE_SECOND = 2'd1;
  localparam logic [1:0] CAUSE_INPUT  = 2'd2;

  // Result kinds loaded into the output register
  typedef logic [2:0] res_t;
  localparam res_t RES_NONE   = 3'd0;
  localparam res_t RES_WS     = 3'd1;  // buffered whitespace byte
  localparam res_t RES_SP     = 3'd2;  // space for a collapsed line break
  localparam res_t RES_ESC    = 3'd3;  // kept backslash
  localparam res_t RES_BYTE   = 3'd4;  // latched token byte
  localparam res_t RES_DIRECT = 3'd5;  // token byte straight from the input beat
  localparam res_t RES_END    = 3'd6;  // end record

  // Controller to datapath
  typedef struct packed {
    logic accept;
    res_t res;
    logic res_last;
  } qte_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dec_emit;    // input beat emits a byte
    logic dec_nl;      // line break pending before this beat
    logic dec_ws_any;  // whitespace buffered before this beat
    logic dec_extra;   // escaped byte, backslash goes first
    logic dec_end;     // input beat closes the token
    logic plan_extra;
    logic plan_end;
    logic ws_last;     // flush pointer at the last buffered byte
    logic out_free;    // output register can take a result
  } qte_stat_t;

endpackage

// ===== hw/rtl/quoted_token_extractor_unit.sv =====
// Quoted token extractor: one input byte per beat, cleaned token bytes
// and end records out. A plain token byte is loaded into the output register
// as its beat is accepted; one byte per cycle sustained while out_tready holds.
// A byte that flushes buffered whitespace sends the buffered bytes, or one
// line break space, then any kept backslash, itself and any end record.
// Reset (rst_n low, synchronous) clears token state and sets delimiters to '#' and LF.
`timescale 1ns / 1ps

module quoted_token_extractor_unit #(
  parameter int WS_MAX      = qte_pkg::WS_MAX_DEF,
  parameter int COUNT_WIDTH = qte_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: [7:0] in_byte; in_tlast: last_byte
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [qte_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tlast,
  // cfg_index 0 first_delimiter, 1 second_delimiter
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qte_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qte_pkg::CFG_DATA_W-1:0]   cfg_data,
  // out_tdata: [7:0] out_byte, [9:8] stop_cause, [25:10] token_length,
  // [41:26] consumed_count, [57:42] line_breaks, [58] warn_trailing_slash,
  // [59] warn_open_quote, [60] warn_ws_overflow, [63:61] zero
  // out_tuser: token_end; out_tlast: last_of_run
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [qte_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast
);
  import qte_pkg::*;

  qte_cmd_t  cmd;
  qte_stat_t stat;

  qte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  qte_datapath #(
    .WS_MAX      (WS_MAX),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ===== hw/rtl/qte_ctrl.sv =====
// Sequencer of the quoted token extractor: accepts input beats and orders
// the results of each beat. Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  qte_pkg::qte_stat_t   stat,
  output qte_pkg::qte_cmd_t    cmd
);
  import qte_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SP   = 3'd1;
  localparam logic [2:0] S_WS   = 3'd2;
  localparam logic [2:0] S_ESC  = 3'd3;
  localparam logic [2:0] S_BYTE = 3'd4;
  localparam logic [2:0] S_END  = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE) && stat.out_free;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.res      = RES_NONE;
    cmd.res_last = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && stat.out_free) begin
          cmd.accept = 1'b1;
          if (stat.dec_emit) begin
            if (stat.dec_nl) begin
              state_nxt = S_SP;
            end else if (stat.dec_ws_any) begin
              state_nxt = S_WS;
            end else if (stat.dec_extra) begin
              state_nxt = S_ESC;
            end else begin
              // plain byte goes out at once
              cmd.res      = RES_DIRECT;
              cmd.res_last = !stat.dec_end;
              state_nxt    = stat.dec_end ? S_END : S_IDLE;
            end
          end else if (stat.dec_end) begin
            state_nxt = S_END;
          end
        end
      end
      S_SP: begin
        if (stat.out_free) begin
          cmd.res   = RES_SP;
          state_nxt = stat.plan_extra ? S_ESC : S_BYTE;
        end
      end
      S_WS: begin
        if (stat.out_free) begin
          cmd.res = RES_WS;
          if (stat.ws_last) begin
            state_nxt = stat.plan_extra ? S_ESC : S_BYTE;
          end
        end
      end
      S_ESC: begin
        if (stat.out_free) begin
          cmd.res   = RES_ESC;
          state_nxt = S_BYTE;
        end
      end
      S_BYTE: begin
        if (stat.out_free) begin
          cmd.res      = RES_BYTE;
          cmd.res_last = !stat.plan_end;
          state_nxt    = stat.plan_end ? S_END : S_IDLE;
        end
      end
      S_END: begin
        if (stat.out_free) begin
          cmd.res      = RES_END;
          cmd.res_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/qte_datapath.sv =====
// Datapath of the quoted token extractor: byte decode, token state,
// whitespace buffer, counters and output register. Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_datapath #(
  parameter int WS_MAX      = qte_pkg::WS_MAX_DEF,
  parameter int COUNT_WIDTH = qte_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [qte_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qte_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qte_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [qte_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast,
  input  qte_pkg::qte_cmd_t                cmd,
  output qte_pkg::qte_stat_t               stat
);
  import qte_pkg::*;

  localparam int CNT_W = $clog2(WS_MAX + 1);
  localparam int AW    = $clog2(WS_MAX);

  // Configuration
  logic [7:0] delim0_r, delim1_r;

  // Token state
  logic                   esc_r, esc_nxt;
  logic [1:0]             quote_r, quote_nxt;
  logic                   nl_r, nl_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] emitted_r, emitted_nxt;
  logic [COUNT_WIDTH-1:0] consumed_r, consumed_nxt;
  logic [COUNT_WIDTH-1:0] line_r, line_nxt;
  logic                   ovf_r, ovf_nxt;

  // Plan of the beat being worked off
  logic [7:0]       byte_r;
  logic             plan_extra_r, plan_end_r;
  logic [1:0]       cause_r;
  logic [CNT_W-1:0] flush_cnt_r;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;

  // Whitespace buffer
  logic [7:0] ws_mem [WS_MAX];
  logic [7:0] rd_data_r;
  logic       ws_wr;

  // Output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r, out_last_r;
  logic                  out_free, load, load_byte;

  // Decode
  logic [7:0] b;
  logic       d_emit, d_extra, d_stop, d_lb, d_ws, d_esc;
  logic [1:0] d_quote, d_cause;
  logic [7:0] qc;
  logic       is_sp;

  // Capped counts for the end record
  logic [15:0] cap_len, cap_cons, cap_line;

  assign b     = in_tdata[7:0];
  assign is_sp = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR);
  assign qc    = (quote_r == Q_DOUBLE) ? CH_DQ : CH_SQ;

  // Classify the input byte against the token state
  always_comb begin
    d_emit  = 1'b0;
    d_extra = 1'b0;
    d_stop  = 1'b0;
    d_lb    = 1'b0;
    d_ws    = 1'b0;
    d_esc   = esc_r;
    d_quote = quote_r;
    d_cause = CAUSE_INPUT;
    if (esc_r) begin
      d_esc = 1'b0;
      if (b == CH_LF) begin
        d_lb = 1'b1;
      end else begin
        d_extra = 1'b1;
        d_emit  = 1'b1;
      end
    end else if (b == CH_BSL) begin
      d_esc = 1'b1;
    end else if (quote_r != Q_NONE) begin
      if (b == qc) begin
        d_quote = Q_NONE;
        d_emit  = 1'b1;
      end else if (b == CH_LF) begin
        d_lb = 1'b1;
      end else if (is_sp) begin
        d_ws = 1'b1;
      end else begin
        d_emit = 1'b1;
      end
    end else if (b == CH_DQ) begin
      d_quote = Q_DOUBLE;
      d_emit  = 1'b1;
    end else if (b == CH_SQ) begin
      d_quote = Q_SINGLE;
      d_emit  = 1'b1;
    end else if (b == delim0_r) begin
      d_stop  = 1'b1;
      d_cause = CAUSE_FIRST;
    end else if (b == delim1_r) begin
      d_stop  = 1'b1;
      d_cause = CAUSE_SECOND;
    end else if (is_sp) begin
      d_ws = 1'b1;
    end else begin
      d_emit = 1'b1;
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign load      = (cmd.res != RES_NONE);
  assign load_byte = load && (cmd.res != RES_END);
  assign ws_wr     = cmd.accept && d_ws && !nl_r && (cnt_r < CNT_W'(WS_MAX));

  // Status to the controller
  always_comb begin
    stat.dec_emit   = d_emit;
    stat.dec_nl     = nl_r;
    stat.dec_ws_any = (cnt_r != '0);
    stat.dec_extra  = d_extra;
    stat.dec_end    = d_stop || in_tlast;
    stat.plan_extra = plan_extra_r;
    stat.plan_end   = plan_end_r;
    stat.ws_last    = ((ptr_r + CNT_W'(1)) == flush_cnt_r);
    stat.out_free   = out_free;
  end

  // Token state next values
  always_comb begin
    esc_nxt      = esc_r;
    quote_nxt    = quote_r;
    nl_nxt       = nl_r;
    cnt_nxt      = cnt_r;
    emitted_nxt  = emitted_r;
    consumed_nxt = consumed_r;
    line_nxt     = line_r;
    ovf_nxt      = ovf_r;
    if (cmd.accept) begin
      esc_nxt   = d_esc;
      quote_nxt = d_quote;
      if (!d_stop && !(&consumed_r)) begin
        consumed_nxt = consumed_r + COUNT_WIDTH'(1);
      end
      if (d_lb) begin
        nl_nxt  = 1'b1;
        cnt_nxt = '0;
        if (!(&line_r)) begin
          line_nxt = line_r + COUNT_WIDTH'(1);
        end
      end
      if (d_ws && !nl_r) begin
        if (cnt_r < CNT_W'(WS_MAX)) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      if (d_emit) begin
        cnt_nxt = '0;
        nl_nxt  = 1'b0;
      end
    end
    if (load_byte && !(&emitted_r)) begin
      emitted_nxt = emitted_r + COUNT_WIDTH'(1);
    end
    if (cmd.res == RES_END) begin
      esc_nxt      = 1'b0;
      quote_nxt    = Q_NONE;
      nl_nxt       = 1'b0;
      cnt_nxt      = '0;
      emitted_nxt  = '0;
      consumed_nxt = '0;
      line_nxt     = '0;
      ovf_nxt      = 1'b0;
    end
  end

  // Flush read pointer
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.accept) begin
      ptr_nxt = '0;
    end else if (cmd.res == RES_WS) begin
      ptr_nxt = ptr_r + CNT_W'(1);
    end
  end

  // Count capping for the 16-bit report fields
  generate
    if (COUNT_WIDTH > 16) begin : g_cap
      assign cap_len  = (|emitted_r[COUNT_WIDTH-1:16])  ? 16'hFFFF : emitted_r[15:0];
      assign cap_cons = (|consumed_r[COUNT_WIDTH-1:16]) ? 16'hFFFF : consumed_r[15:0];
      assign cap_line = (|line_r[COUNT_WIDTH-1:16])     ? 16'hFFFF : line_r[15:0];
    end else begin : g_ext
      assign cap_len  = 16'(emitted_r);
      assign cap_cons = 16'(consumed_r);
      assign cap_line = 16'(line_r);
    end
  endgenerate

  // Result payload: byte, cause, length, consumed, lines, three warnings
  always_comb begin
    out_data_nxt = '0;
    case (cmd.res)
      RES_WS:     out_data_nxt[7:0] = rd_data_r;
      RES_SP:     out_data_nxt[7:0] = CH_SPACE;
      RES_ESC:    out_data_nxt[7:0] = CH_BSL;
      RES_BYTE:   out_data_nxt[7:0] = byte_r;
      RES_DIRECT: out_data_nxt[7:0] = b;
      RES_END: begin
        out_data_nxt[9:8]   = cause_r;
        out_data_nxt[25:10] = cap_len;
        out_data_nxt[41:26] = cap_cons;
        out_data_nxt[57:42] = cap_line;
        out_data_nxt[58]    = (cause_r == CAUSE_INPUT) && esc_r;
        out_data_nxt[59]    = (cause_r == CAUSE_INPUT) && (quote_r != Q_NONE);
        out_data_nxt[60]    = ovf_r;
      end
      default: out_data_nxt = '0;
    endcase
  end

  // Control and token state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim0_r    <= FIRST_DELIM_RST;
      delim1_r    <= SECOND_DELIM_RST;
      esc_r       <= 1'b0;
      quote_r     <= Q_NONE;
      nl_r        <= 1'b0;
      cnt_r       <= '0;
      emitted_r   <= '0;
      consumed_r  <= '0;
      line_r      <= '0;
      ovf_r       <= 1'b0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_index == CFG_FIRST_DELIM)) begin
        delim0_r <= cfg_data;
      end
      if (cfg_valid && (cfg_index == CFG_SECOND_DELIM)) begin
        delim1_r <= cfg_data;
      end
      esc_r      <= esc_nxt;
      quote_r    <= quote_nxt;
      nl_r       <= nl_nxt;
      cnt_r      <= cnt_nxt;
      emitted_r  <= emitted_nxt;
      consumed_r <= consumed_nxt;
      line_r     <= line_nxt;
      ovf_r      <= ovf_nxt;
      ptr_r      <= ptr_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Beat plan and output payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r       <= b;
      plan_extra_r <= d_extra;
      plan_end_r   <= d_stop || in_tlast;
      cause_r      <= d_cause;
      flush_cnt_r  <= cnt_r;
    end
    if (load) begin
      out_data_r <= out_data_nxt;
      out_user_r <= (cmd.res == RES_END);
      out_last_r <= cmd.res_last;
    end
  end

  // Whitespace buffer, registered read
  always_ff @(posedge clk) begin
    if (ws_wr) begin
      ws_mem[cnt_r[AW-1:0]] <= b;
    end
    rd_data_r <= ws_mem[ptr_nxt[AW-1:0]];
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WS_MAX)) else $error("whitespace count beyond buffer");

  a_nl_empty: assert property (@(posedge clk) disable iff (!rst_n)
    nl_r |-> (cnt_r == '0)) else $error("whitespace buffered after line break");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> out_free) else $error("result loaded over a waiting result");

  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res == RES_END) |=> (emitted_r == '0) && (consumed_r == '0) && (line_r == '0))
    else $error("token counters not cleared after end record");

  a_ws_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res == RES_WS) |-> (ptr_r < flush_cnt_r)) else $error("flush past buffer fill");

endmodule

// ===== bench/quoted_token_extractor_unit_test.sv =====
// Self-checking bench for quoted_token_extractor_unit: a short stimulus table, then
// random text under several delimiter settings, checked by a local predictor or typed
// end records. Depends on qte_pkg and the quoted_token_extractor_unit RTL only.
`timescale 1ns / 1ps

module quoted_token_extractor_unit_test;
  import qte_pkg::*;

  localparam int DIR_ROWS        = 28;
  localparam int ITEMS_PER_PHASE = 32;
  localparam int NUM_PHASES      = 6;
  localparam int SETTLE_CYCLES   = 48;
  localparam int STALL_LIMIT     = 3000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // One result beat, decoded
  typedef struct packed {
    logic [7:0]  ch;
    logic        fin;
    logic [1:0]  cause;
    logic [15:0] len;
    logic [15:0] cons;
    logic [15:0] lines;
    logic        ts;
    logic        oq;
    logic        ov;
    logic        run_end;
  } tok_res_t;

  // End record fields that can be typed in by hand
  typedef struct packed {
    logic [1:0]  cause;
    logic [15:0] len;
    logic [15:0] cons;
    logic [15:0] lines;
    logic        ts;
    logic        oq;
    logic        ov;
  } end_exp_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
    logic [5:0] reps;
    logic       typed;
    end_exp_t   want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic in_tready;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic cfg_ready;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  quoted_token_extractor_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  // Directed text: default delimiters, typed end records where obvious
  stim_row_t stim_plan [DIR_ROWS] = '{
    '{FIRST_DELIM_RST, 1'b0, 6'd1,  1'b1, '{CAUSE_FIRST, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
    '{CH_LF,           1'b1, 6'd1,  1'b1, '{CAUSE_SECOND, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
    '{8'h61,           1'b1, 6'd1,  1'b0, '0},
    '{CH_SPACE,        1'b0, 6'd1,  1'b0, '0},
    '{CH_TAB,          1'b0, 6'd1,  1'b0, '0},
    '{8'h62,           1'b0, 6'd1,  1'b0, '0},
    '{CH_BSL,          1'b0, 6'd1,  1'b0, '0},
    '{CH_LF,           1'b0, 6'd1,  1'b0, '0},
    '{CH_SPACE,        1'b0, 6'd1,  1'b0, '0},
    '{8'h63,           1'b0, 6'd1,  1'b0, '0},
    '{CH_BSL,          1'b0, 6'd1,  1'b0, '0},
    '{8'h71,           1'b0, 6'd1,  1'b0, '0},
    '{CH_DQ,           1'b0, 6'd1,  1'b0, '0},
    '{FIRST_DELIM_RST, 1'b0, 6'd1,  1'b0, '0},
    '{CH_LF,           1'b0, 6'd1,  1'b0, '0},
    '{CH_CR,           1'b0, 6'd1,  1'b0, '0},
    '{CH_DQ,           1'b0, 6'd1,  1'b0, '0},
    '{CH_SQ,           1'b0, 6'd1,  1'b0, '0},
    '{8'h78,           1'b0, 6'd1,  1'b0, '0},
    '{CH_SPACE,        1'b1, 6'd1,  1'b0, '0},
    '{CH_BSL,          1'b1, 6'd1,  1'b1, '{CAUSE_INPUT, 16'd0, 16'd1, 16'd0, 1'b1, 1'b0, 1'b0}},
    '{CH_SQ,           1'b1, 6'd1,  1'b0, '0},
    '{8'h00,           1'b0, 6'd1,  1'b0, '0},
    '{8'hFF,           1'b0, 6'd1,  1'b0, '0},
    '{CH_SPACE,        1'b0, 6'd34, 1'b0, '0},
    '{CH_BSL,          1'b0, 6'd1,  1'b0, '0},
    '{8'h7A,           1'b1, 6'd1,  1'b0, '0},
    '{FIRST_DELIM_RST, 1'b0, 6'd1,  1'b1, '{CAUSE_FIRST, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0}}
  };

  // Delimiter settings per random phase: defaults, extremes, role bytes, equal blanks
  logic [7:0] phase_first  [NUM_PHASES] = '{FIRST_DELIM_RST, 8'h00, 8'hFF, CH_BSL, CH_SPACE, CH_SQ};
  logic [7:0] phase_second [NUM_PHASES] = '{SECOND_DELIM_RST, 8'hFF, 8'h00, CH_DQ, CH_SPACE, CH_TAB};

  // Predictor state
  logic [7:0]  delim_first, delim_second;
  logic        esc_on, nl_pend, ovf_seen;
  logic [1:0]  qkind;
  int          ws_cnt;
  logic [7:0]  ws_buf [32];
  logic [15:0] emit_cnt, cons_cnt, line_cnt;

  tok_res_t token_beats_due [$];
  tok_res_t step_beats [$];

  int send_idle_pct, recv_idle_pct;
  int fail_count = 0;
  int bytes_fed = 0;
  int beats_seen = 0;
  int ends_seen = 0;
  int stall_cycles = 0;

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_CR;
  endfunction

  function automatic logic [7:0] pick_text();
    return 8'($urandom_range(33, 126));
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(2))
      0: return CH_SPACE;
      1: return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  task automatic clear_token();
    esc_on = 1'b0;
    qkind = Q_NONE;
    nl_pend = 1'b0;
    ws_cnt = 0;
    emit_cnt = '0;
    cons_cnt = '0;
    line_cnt = '0;
    ovf_seen = 1'b0;
  endtask

  task automatic take_break();
    nl_pend = 1'b1;
    ws_cnt = 0;
    line_cnt = sat16(line_cnt);
  endtask

  // Whitespace is dropped after a line break and past the buffer depth
  task automatic hold_blank(input logic [7:0] b);
    if (!nl_pend) begin
      if (ws_cnt < WS_MAX_DEF) begin
        ws_buf[ws_cnt] = b;
        ws_cnt++;
      end else begin
        ovf_seen = 1'b1;
      end
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    tok_res_t r;
    r = '0;
    r.ch = b;
    step_beats.push_back(r);
    emit_cnt = sat16(emit_cnt);
  endtask

  // Expected beats for one input byte, left in step_beats
  task automatic extract_step(input logic [7:0] b, input logic lst);
    logic emit, extra, stop;
    logic [1:0] cause;
    logic [7:0] qc;
    tok_res_t r;
    emit = 1'b0;
    extra = 1'b0;
    stop = 1'b0;
    cause = CAUSE_INPUT;
    step_beats.delete();
    if (esc_on) begin
      esc_on = 1'b0;
      if (b == CH_LF) take_break();
      else begin
        extra = 1'b1;
        emit = 1'b1;
      end
    end else if (b == CH_BSL) begin
      esc_on = 1'b1;
    end else if (qkind != Q_NONE) begin
      qc = (qkind == Q_DOUBLE) ? CH_DQ : CH_SQ;
      if (b == qc) begin
        qkind = Q_NONE;
        emit = 1'b1;
      end else if (b == CH_LF) take_break();
      else if (is_blank(b)) hold_blank(b);
      else emit = 1'b1;
    end else if (b == CH_DQ) begin
      qkind = Q_DOUBLE;
      emit = 1'b1;
    end else if (b == CH_SQ) begin
      qkind = Q_SINGLE;
      emit = 1'b1;
    end else if (b == delim_first) begin
      stop = 1'b1;
      cause = CAUSE_FIRST;
    end else if (b == delim_second) begin
      stop = 1'b1;
      cause = CAUSE_SECOND;
    end else if (is_blank(b)) hold_blank(b);
    else emit = 1'b1;

    if (!stop) cons_cnt = sat16(cons_cnt);

    // Flush pending whitespace, or one space for a collapsed line break
    if (emit) begin
      if (nl_pend) push_byte(CH_SPACE);
      else for (int k = 0; k < ws_cnt; k++) push_byte(ws_buf[k]);
      if (extra) push_byte(CH_BSL);
      push_byte(b);
      ws_cnt = 0;
      nl_pend = 1'b0;
    end

    if (stop || lst) begin
      r = '0;
      r.fin = 1'b1;
      r.cause = cause;
      r.len = emit_cnt;
      r.cons = cons_cnt;
      r.lines = line_cnt;
      r.ts = !stop && esc_on;
      r.oq = !stop && qkind != Q_NONE;
      r.ov = ovf_seen;
      step_beats.push_back(r);
      clear_token();
    end

    if (step_beats.size() > 0) begin
      r = step_beats.pop_back();
      r.run_end = 1'b1;
      step_beats.push_back(r);
    end
  endtask

  // One input beat; valid stays high after acceptance unless the next call idles
  task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input end_exp_t want);
    tok_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= lst;
    extract_step(b, lst);
    if (typed) begin
      r = '0;
      r.fin = 1'b1;
      r.cause = want.cause;
      r.len = want.len;
      r.cons = want.cons;
      r.lines = want.lines;
      r.ts = want.ts;
      r.oq = want.oq;
      r.ov = want.ov;
      r.run_end = 1'b1;
      token_beats_due.push_back(r);
    end else begin
      foreach (step_beats[i]) token_beats_due.push_back(step_beats[i]);
    end
    do @(posedge clk); while (!in_tready);
    bytes_fed++;
  endtask

  // Random text made mostly of plausible pieces
  task automatic send_chunk();
    int kind, n;
    logic [7:0] q, b;
    kind = $urandom_range(99);
    if (kind < 30) begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(pick_text(), 1'b0, 1'b0, '0);
    end else if (kind < 46) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 4);
      repeat (n) send_byte(pick_blank(), 1'b0, 1'b0, '0);
    end else if (kind < 62) begin
      q = $urandom_range(1) ? CH_DQ : CH_SQ;
      send_byte(q, 1'b0, 1'b0, '0);
      n = $urandom_range(0, 5);
      repeat (n) begin
        case ($urandom_range(5))
          0, 1: b = pick_text();
          2: b = pick_blank();
          3: b = CH_LF;
          4: b = delim_first;
          default: b = $urandom_range(1) ? CH_DQ : CH_SQ;
        endcase
        send_byte(b, 1'b0, 1'b0, '0);
      end
      if ($urandom_range(4) != 0) send_byte(q, 1'b0, 1'b0, '0);
    end else if (kind < 72) begin
      send_byte(CH_BSL, 1'b0, 1'b0, '0);
      send_byte($urandom_range(1) ? CH_LF : 8'($urandom_range(255)), 1'b0, 1'b0, '0);
    end else if (kind < 82) begin
      send_byte($urandom_range(1) ? delim_first : delim_second, 1'b0, 1'b0, '0);
    end else if (kind < 88) begin
      send_byte(CH_LF, 1'b0, 1'b0, '0);
    end else if (kind < 94) begin
      send_byte(8'($urandom_range(255)), 1'b0, 1'b0, '0);
    end else begin
      // end of input on an assortment of bytes
      case ($urandom_range(7))
        0: b = pick_text();
        1: b = CH_BSL;
        2: b = pick_blank();
        3: b = CH_DQ;
        4: b = CH_SQ;
        5: b = delim_first;
        6: b = delim_second;
        default: b = 8'($urandom_range(255));
      endcase
      send_byte(b, 1'b1, 1'b0, '0);
    end
  endtask

  // Hold input until every expected beat is out, then let the block go quiet
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (token_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Caller lowers cfg_valid once after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FIRST_DELIM) delim_first = val;
    else if (idx == CFG_SECOND_DELIM) delim_second = val;
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      fail_count++;
    end
  endtask

  // Receiver stalls
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Result checker
  always @(posedge clk) begin
    tok_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ch = out_tdata[7:0];
      got.cause = out_tdata[9:8];
      got.len = out_tdata[25:10];
      got.cons = out_tdata[41:26];
      got.lines = out_tdata[57:42];
      got.ts = out_tdata[58];
      got.oq = out_tdata[59];
      got.ov = out_tdata[60];
      got.fin = out_tuser;
      got.run_end = out_tlast;
      beats_seen++;
      if (got.fin) ends_seen++;
      if (token_beats_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        fail_count++;
      end else begin
        want = token_beats_due.pop_front();
        cmp_field("out_byte", 16'(want.ch), 16'(got.ch));
        cmp_field("token_end", 16'(want.fin), 16'(got.fin));
        cmp_field("stop_cause", 16'(want.cause), 16'(got.cause));
        cmp_field("token_length", want.len, got.len);
        cmp_field("consumed_count", want.cons, got.cons);
        cmp_field("line_breaks", want.lines, got.lines);
        cmp_field("warn_trailing_slash", 16'(want.ts), 16'(got.ts));
        cmp_field("warn_open_quote", 16'(want.oq), 16'(got.oq));
        cmp_field("warn_ws_overflow", 16'(want.ov), 16'(got.ov));
        cmp_field("last_of_run", 16'(want.run_end), 16'(got.run_end));
        cmp_field("tdata_pad", 16'd0, 16'(out_tdata[63:61]));
      end
    end
  end

  // Watchdog on cycles with no beat moving anywhere
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    send_idle_pct = 27;
    recv_idle_pct = 71;
    delim_first = FIRST_DELIM_RST;
    delim_second = SECOND_DELIM_RST;
    clear_token();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (stim_plan[i])
      repeat (stim_plan[i].reps)
        send_byte(stim_plan[i].ch, stim_plan[i].lst, stim_plan[i].typed, stim_plan[i].want);

    // Random phases, each under its own delimiter pair and one of three idle mixes
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_block();
      write_reg(CFG_FIRST_DELIM, phase_first[ph]);
      write_reg(CFG_SECOND_DELIM, phase_second[ph]);
      if (ph == 2) write_reg(CFG_SPARE_IDX, 8'hA5);
      cfg_valid <= 1'b0;
      if (ph < 2) begin
        send_idle_pct = 27;
        recv_idle_pct = 71;
      end else if (ph < 4) begin
        send_idle_pct = 71;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // close any open token so each phase starts clean
      send_byte(pick_text(), 1'b1, 1'b0, '0);
      for (int n0 = bytes_fed; bytes_fed - n0 < ITEMS_PER_PHASE; ) send_chunk();
    end
    settle_block();

    $display("Fed %0d text bytes under %0d delimiter settings with three stall mixes.",
             bytes_fed, NUM_PHASES);
    $display("Checked %0d result beats, %0d of them end records.", beats_seen, ends_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
